>>> design/axis_cumulative_product_macros.svh
// ----------------------------------------------------------------------------
// axis_cumulative_product assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_CUMULATIVE_PRODUCT_MACROS_SVH
`define AXIS_CUMULATIVE_PRODUCT_MACROS_SVH

// same-cycle implication
`define ACP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Widths, register indexes and types for the axis cumulative product block.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int COUNT_WIDTH     = 16;
  localparam int INDEX_WIDTH     = 32;
  localparam int ACC_WIDTH       = 64;
  localparam int HALF_WIDTH      = ACC_WIDTH / 2;
  localparam int PROD_WIDTH      = ACC_WIDTH + DATA_WIDTH;
  localparam int CFG_DATA_WIDTH  = COUNT_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER_STRIDE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTER_COUNT    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXCLUSIVE_MODE = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REVERSE_MODE   = 3'd4;

  // accumulator kept as sign and magnitude
  typedef struct packed {
    logic                 neg;
    logic [ACC_WIDTH-1:0] mag;
  } acc_t;

  typedef struct packed {
    acc_t acc;
    logic clamped;
  } mul_res_t;

  localparam logic [ACC_WIDTH-1:0] ACC_POS_LIMIT = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_NEG_LIMIT = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam acc_t ACC_ONE = '{neg: 1'b0, mag: ACC_WIDTH'(1)};

  localparam logic [ACC_WIDTH-1:0] EMIT_POS_MAG =
    {{(ACC_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] EMIT_NEG_MAG = EMIT_POS_MAG + ACC_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // a size of zero acts as one
  function automatic logic [COUNT_WIDTH-1:0] eff_size(input logic [COUNT_WIDTH-1:0] r);
    eff_size = (r == '0) ? COUNT_WIDTH'(1) : r;
  endfunction

endpackage

>>> design/acp_sat_mul.sv
// ----------------------------------------------------------------------------
// acp_sat_mul
// Saturating accumulator step: sign-magnitude 64-bit product times a signed
// element, clamped to the signed 64-bit range of the true sign.
// ----------------------------------------------------------------------------
module acp_sat_mul
  import acp_pkg::*;
(
  input  acc_t                   acc_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  output mul_res_t               res_o
);

  logic                            vneg;
  logic [DATA_WIDTH-1:0]           vmag;
  logic [HALF_WIDTH+DATA_WIDTH-1:0] pp_hi;
  logic [HALF_WIDTH+DATA_WIDTH-1:0] pp_lo;
  logic [PROD_WIDTH-1:0]           full;
  logic                            neg;
  logic [ACC_WIDTH-1:0]            limit;
  logic                            over;

  assign vneg  = value_i[DATA_WIDTH-1];
  assign vmag  = vneg ? (~value_i + DATA_WIDTH'(1)) : value_i;
  assign pp_hi = (HALF_WIDTH+DATA_WIDTH)'(acc_i.mag[ACC_WIDTH-1:HALF_WIDTH])
               * (HALF_WIDTH+DATA_WIDTH)'(vmag);
  assign pp_lo = (HALF_WIDTH+DATA_WIDTH)'(acc_i.mag[HALF_WIDTH-1:0])
               * (HALF_WIDTH+DATA_WIDTH)'(vmag);
  assign full  = {pp_hi, {HALF_WIDTH{1'b0}}} + PROD_WIDTH'(pp_lo);
  assign neg   = acc_i.neg ^ vneg;
  assign limit = neg ? ACC_NEG_LIMIT : ACC_POS_LIMIT;
  assign over  = full > PROD_WIDTH'(limit);

  always_comb begin
    res_o.clamped = over;
    res_o.acc.mag = over ? limit : full[ACC_WIDTH-1:0];
    res_o.acc.neg = neg && (full != '0);
  end

endmodule

>>> design/axis_cumulative_product.sv
// Pipeline: an accepted input is registered in the input stage, then the result
// stage. Throughput: one item per cycle while out_stall is low; the accumulator
// loop through the 64x32 saturating multiply in acp_sat_mul sets the cycle time.
// Reset (rst_n low, synchronous): product back to one, all counters to zero,
// registers to axis_length = inner_stride = outer_count = 1, both modes off.
// ----------------------------------------------------------------------------
// axis_cumulative_product
// Running product along one tensor axis with memory index and lane/tensor
// end marks; 64-bit accumulator and output saturate.
// ----------------------------------------------------------------------------
`include "axis_cumulative_product_macros.svh"

module axis_cumulative_product
  import acp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_element_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_WIDTH-1:0] out_product_value,
  output logic [INDEX_WIDTH-1:0]     out_element_index,
  output logic                       out_lane_done,
  output logic                       out_tensor_done,
  output logic                       out_saturated,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic [COUNT_WIDTH-1:0] axis_length_r, inner_stride_r, outer_count_r;
  logic                   exclusive_mode_r, reverse_mode_r;

  logic [COUNT_WIDTH-1:0] axis_pos_r, lane_pos_r, block_pos_r;

  logic                   s1_valid_r;
  logic [DATA_WIDTH-1:0]  s1_value_r;
  logic [INDEX_WIDTH-1:0] s1_base_r;
  logic [COUNT_WIDTH-1:0] s1_lane_r;
  logic                   s1_last_axis_r;
  logic                   s1_tensor_done_r;

  acc_t                   acc_r, acc_nxt;

  logic                   out_valid_r;
  logic [DATA_WIDTH-1:0]  out_product_r;
  logic [INDEX_WIDTH-1:0] out_index_r;
  logic                   out_lane_done_r, out_tensor_done_r, out_saturated_r;

  logic [COUNT_WIDTH-1:0]   len, lanes, blocks, c;
  logic                     last_axis, last_lane, last_block;
  logic [2*COUNT_WIDTH-1:0] blk_len;
  logic [INDEX_WIDTH-1:0]   base_nxt, idx_mul, index_nxt;
  logic                     out_en, s1_en, in_acc, s1_move;

  mul_res_t               mul_res;
  acc_t                   emit_acc;
  logic                   emit_clamp;
  logic [DATA_WIDTH-1:0]  product_nxt;
  logic                   saturated_nxt;

  // handshake
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign in_acc   = in_valid && s1_en;
  assign s1_move  = s1_valid_r && out_en;

  // position bookkeeping
  assign len        = eff_size(axis_length_r);
  assign lanes      = eff_size(inner_stride_r);
  assign blocks     = eff_size(outer_count_r);
  assign last_axis  = axis_pos_r >= len - COUNT_WIDTH'(1);
  assign last_lane  = lane_pos_r >= lanes - COUNT_WIDTH'(1);
  assign last_block = block_pos_r >= blocks - COUNT_WIDTH'(1);

  always_comb begin
    if (reverse_mode_r) begin
      c = (axis_pos_r >= len) ? '0 : len - COUNT_WIDTH'(1) - axis_pos_r;
    end else begin
      c = axis_pos_r;
    end
  end

  assign blk_len   = (2*COUNT_WIDTH)'(block_pos_r) * (2*COUNT_WIDTH)'(len);
  assign base_nxt  = INDEX_WIDTH'(blk_len + (2*COUNT_WIDTH)'(c));
  assign idx_mul   = s1_base_r * INDEX_WIDTH'(lanes);
  assign index_nxt = idx_mul + INDEX_WIDTH'(s1_lane_r);

  // accumulator step
  acp_sat_mul u_sat_mul (
    .acc_i   (acc_r),
    .value_i (s1_value_r),
    .res_o   (mul_res)
  );

  assign emit_acc = exclusive_mode_r ? acc_r : mul_res.acc;
  assign emit_clamp = emit_acc.neg ? (emit_acc.mag > EMIT_NEG_MAG)
                                   : (emit_acc.mag > EMIT_POS_MAG);

  always_comb begin
    if (emit_clamp) begin
      product_nxt = emit_acc.neg ? DATA_MIN : DATA_MAX;
    end else if (emit_acc.neg) begin
      product_nxt = ~emit_acc.mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
    end else begin
      product_nxt = emit_acc.mag[DATA_WIDTH-1:0];
    end
  end

  assign saturated_nxt = emit_clamp || (!exclusive_mode_r && mul_res.clamped);

  always_comb begin
    acc_nxt = acc_r;
    if (s1_move) begin
      acc_nxt = s1_last_axis_r ? ACC_ONE : mul_res.acc;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_length_r    <= COUNT_WIDTH'(1);
      inner_stride_r   <= COUNT_WIDTH'(1);
      outer_count_r    <= COUNT_WIDTH'(1);
      exclusive_mode_r <= 1'b0;
      reverse_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AXIS_LENGTH:    axis_length_r    <= cfg_data;
        REG_INNER_STRIDE:   inner_stride_r   <= cfg_data;
        REG_OUTER_COUNT:    outer_count_r    <= cfg_data;
        REG_EXCLUSIVE_MODE: exclusive_mode_r <= cfg_data[0];
        REG_REVERSE_MODE:   reverse_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_pos_r  <= '0;
      lane_pos_r  <= '0;
      block_pos_r <= '0;
    end else if (in_acc) begin
      if (last_axis) begin
        axis_pos_r <= '0;
        if (last_lane) begin
          lane_pos_r  <= '0;
          block_pos_r <= last_block ? '0 : block_pos_r + COUNT_WIDTH'(1);
        end else begin
          lane_pos_r <= lane_pos_r + COUNT_WIDTH'(1);
        end
      end else begin
        axis_pos_r <= axis_pos_r + COUNT_WIDTH'(1);
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r       <= in_element_value;
      s1_base_r        <= base_nxt;
      s1_lane_r        <= lane_pos_r;
      s1_last_axis_r   <= last_axis;
      s1_tensor_done_r <= last_axis && last_lane && last_block;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_ONE;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_product_r     <= product_nxt;
      out_index_r       <= index_nxt;
      out_lane_done_r   <= s1_last_axis_r;
      out_tensor_done_r <= s1_tensor_done_r;
      out_saturated_r   <= saturated_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_product_r;
  assign out_element_index = out_index_r;
  assign out_lane_done     = out_lane_done_r;
  assign out_tensor_done   = out_tensor_done_r;
  assign out_saturated     = out_saturated_r;

  `ACP_ASSERT_NOW(a_tensor_implies_lane, out_valid_r && out_tensor_done_r, out_lane_done_r, "tensor_done without lane_done")
  `ACP_ASSERT_NEXT(a_acc_restart, s1_move && s1_last_axis_r, acc_r == ACC_ONE, "product not restarted after lane end")
  `ACP_ASSERT_NEXT(a_axis_wrap, in_acc && last_axis, axis_pos_r == '0, "axis counter did not wrap")
  `ACP_ASSERT_NOW(a_acc_bound, 1'b1, acc_r.mag <= ACC_NEG_LIMIT, "accumulator magnitude out of range")
  `ACP_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && out_stall, s1_valid_r, "input stage item lost under stall")

endmodule
